// ===== sv/lcg_pkg.sv =====
// Shared types, constants and sine table builder for the linear chirp generator.
package lcg_pkg;

  localparam int unsigned COUNT_W        = 7;
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned AMP_W          = 15;
  localparam int unsigned PHASE_W        = 48;
  localparam int unsigned TOTAL_W        = 32;
  localparam int unsigned CFG_ADDR_W     = 2;
  localparam int unsigned CFG_DATA_W     = 48;
  localparam int unsigned MAX_BURST_DEF  = 64;
  localparam int unsigned TABLE_BITS_DEF = 10;
  localparam int unsigned JOB_DEPTH_LOG2 = 1;
  localparam int unsigned OUT_DEPTH_LOG2 = 2;

  localparam logic [AMP_W-1:0] AMP_RESET = 15'h7FFF;

  localparam logic CMD_RENDER  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_START_STEP = 2'd0,
    REG_SWEEP_STEP = 2'd1,
    REG_AMPLITUDE  = 2'd2,
    REG_CHIRP_LEN  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] n;
  } job_t;

  typedef struct packed {
    logic                last;
    logic [SAMPLE_W-1:0] q_sample;
    logic [SAMPLE_W-1:0] i_sample;
  } out_item_t;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] DENS [7]    = '{64'd210, 64'd156, 64'd110, 64'd72,
                                          64'd42, 64'd20, 64'd6};

  // Quarter-wave entry: Q30 Taylor series of sin, rounded to Q1.15, capped at 1.0.
  function automatic logic [15:0] sine_entry(input int unsigned idx,
                                             input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (HALF_PI_Q30 * 64'(idx) + (64'd1 << (tbits - 1))) >> tbits;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (int k = 0; k < 7; k++) begin
      t = Q30_ONE - (((x2 * t) / DENS[k]) >> 30);
    end
    s = (x * t) >> 30;
    s = (s + (64'd1 << 14)) >> 15;
    if (s > 64'd32768) begin
      s = 64'd32768;
    end
    return s[15:0];
  endfunction

endpackage

// ===== sv/lcg_fifo.sv =====
// Small register queue with occupancy count.
module lcg_fifo import lcg_pkg::*; #(
  parameter int unsigned WIDTH      = 8,
  parameter int unsigned DEPTH_LOG2 = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  full,
  output logic                  empty,
  output logic [DEPTH_LOG2:0]   count
);

  localparam int unsigned DEPTH = 1 << DEPTH_LOG2;

  logic [WIDTH-1:0]      mem_r [DEPTH];
  logic [DEPTH_LOG2-1:0] wr_ptr_r;
  logic [DEPTH_LOG2-1:0] rd_ptr_r;
  logic [DEPTH_LOG2:0]   count_r;
  logic                  do_push;
  logic                  do_pop;

  assign full     = (count_r == (DEPTH_LOG2 + 1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/lcg_front.sv =====
// Request front end: classify commands, track progress, queue render jobs.
module lcg_front import lcg_pkg::*; #(
  parameter int unsigned MAX_BURST = MAX_BURST_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [COUNT_W-1:0] in_count,
  input  logic [TOTAL_W-1:0] chirp_len,
  input  logic               job_full,
  output logic               job_push,
  output job_t               job_data
);

  logic [TOTAL_W-1:0] produced_r;
  logic [TOTAL_W-1:0] produced_nxt;
  logic [COUNT_W-1:0] req_clip;
  logic [TOTAL_W-1:0] remaining;
  logic [COUNT_W-1:0] n;
  logic               has_left;
  logic               accept;

  assign in_ready  = !job_full;
  assign accept    = in_valid && in_ready;
  assign req_clip  = (in_count > COUNT_W'(MAX_BURST)) ? COUNT_W'(MAX_BURST) : in_count;
  assign has_left  = (chirp_len != '0) && (produced_r < chirp_len);
  assign remaining = chirp_len - produced_r;
  assign n         = (remaining < TOTAL_W'(req_clip)) ? remaining[COUNT_W-1:0] : req_clip;
  assign job_push  = accept && (in_cmd == CMD_RENDER) && has_left && (n != '0);

  assign job_data.start = (produced_r == '0);
  assign job_data.n     = n;

  always_comb begin
    produced_nxt = produced_r;
    if (accept && (in_cmd == CMD_RESTART)) begin
      produced_nxt = '0;
    end else if (job_push) begin
      produced_nxt = produced_r + TOTAL_W'(n);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      produced_r <= '0;
    end else begin
      produced_r <= produced_nxt;
    end
  end

endmodule

// ===== sv/lcg_sine_rom.sv =====
// Dual-read quarter-wave sine ROM with registered outputs.
module lcg_sine_rom import lcg_pkg::*; #(
  parameter int unsigned TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic                clk,
  input  logic [TABLE_BITS:0] addr_a,
  input  logic [TABLE_BITS:0] addr_b,
  output logic [15:0]         data_a_r,
  output logic [15:0]         data_b_r
);

  localparam int unsigned ENTRIES = (1 << TABLE_BITS) + 1;

  typedef logic [15:0] tab_t [ENTRIES];

  function automatic tab_t build_tab();
    tab_t tab;
    for (int i = 0; i < ENTRIES; i++) begin
      tab[i] = sine_entry(i, TABLE_BITS);
    end
    return tab;
  endfunction

  localparam tab_t TAB = build_tab();

  always_ff @(posedge clk) begin
    data_a_r <= TAB[addr_a];
    data_b_r <= TAB[addr_b];
  end

endmodule

// ===== sv/lcg_back.sv =====
// Sample engine: phase/step recurrence, table lookup, amplitude scaling.
module lcg_back import lcg_pkg::*; #(
  parameter int unsigned TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    job_empty,
  input  job_t                    job_data,
  output logic                    job_pop,
  input  logic [PHASE_W-1:0]      start_step,
  input  logic [PHASE_W-1:0]      sweep_step,
  input  logic [AMP_W-1:0]        amplitude,
  input  logic [OUT_DEPTH_LOG2:0] out_count,
  output logic                    out_push,
  output out_item_t               out_data
);

  localparam int unsigned QTR    = 1 << TABLE_BITS;
  localparam int unsigned CRED_W = OUT_DEPTH_LOG2 + 2;
  localparam int unsigned PROD_W = AMP_W + 16;

  bk_state_t          state_r;
  bk_state_t          state_nxt;
  logic [COUNT_W-1:0] left_r;
  logic [PHASE_W-1:0] phase_acc_r;
  logic [PHASE_W-1:0] phase_step_r;
  logic               credit_ok;
  logic               issue;

  logic               s1_v_r;
  logic [1:0]         s1_quad_r;
  logic               s1_last_r;
  logic [TABLE_BITS-1:0] tab_i;
  logic [TABLE_BITS:0]   addr_lo;
  logic [TABLE_BITS:0]   addr_hi;
  logic [15:0]           rom_lo;
  logic [15:0]           rom_hi;
  logic [15:0]           mag_c;
  logic [15:0]           mag_s;

  logic               s2_v_r;
  logic               s2_last_r;
  logic               s2_neg_c_r;
  logic               s2_neg_s_r;
  logic [PROD_W-1:0]  s2_prod_c_r;
  logic [PROD_W-1:0]  s2_prod_s_r;
  logic [PROD_W-1:0]  rnd_c;
  logic [PROD_W-1:0]  rnd_s;
  logic [SAMPLE_W-1:0] mag_out_c;
  logic [SAMPLE_W-1:0] mag_out_s;

  assign credit_ok = (CRED_W'(out_count) + CRED_W'(s1_v_r) + CRED_W'(s2_v_r))
                     < CRED_W'(1 << OUT_DEPTH_LOG2);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!job_empty) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (issue && (left_r == COUNT_W'(1))) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop = 1'b0;
    issue   = 1'b0;
    case (state_r)
      BK_IDLE: job_pop = !job_empty;
      BK_RUN:  issue   = credit_ok;
      default: begin
        job_pop = 1'b0;
        issue   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      left_r       <= '0;
      phase_acc_r  <= '0;
      phase_step_r <= '0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      if (job_pop) begin
        left_r <= job_data.n;
        if (job_data.start) begin
          phase_acc_r  <= '0;
          phase_step_r <= start_step;
        end
      end else if (issue) begin
        left_r       <= left_r - 1'b1;
        phase_acc_r  <= phase_acc_r + phase_step_r;
        phase_step_r <= phase_step_r + sweep_step;
      end
    end
  end

  assign tab_i   = phase_acc_r[PHASE_W-3 -: TABLE_BITS];
  assign addr_lo = {1'b0, tab_i};
  assign addr_hi = (TABLE_BITS + 1)'(QTR) - {1'b0, tab_i};

  lcg_sine_rom #(
    .TABLE_BITS(TABLE_BITS)
  ) u_rom (
    .clk     (clk),
    .addr_a  (addr_lo),
    .addr_b  (addr_hi),
    .data_a_r(rom_lo),
    .data_b_r(rom_hi)
  );

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_quad_r <= phase_acc_r[PHASE_W-1 -: 2];
      s1_last_r <= (left_r == COUNT_W'(1));
    end
  end

  assign mag_c = s1_quad_r[0] ? rom_lo : rom_hi;
  assign mag_s = s1_quad_r[0] ? rom_hi : rom_lo;

  always_ff @(posedge clk) begin
    s2_last_r   <= s1_last_r;
    s2_neg_c_r  <= s1_quad_r[1] ^ s1_quad_r[0];
    s2_neg_s_r  <= s1_quad_r[1];
    s2_prod_c_r <= PROD_W'(amplitude) * PROD_W'(mag_c);
    s2_prod_s_r <= PROD_W'(amplitude) * PROD_W'(mag_s);
  end

  assign rnd_c     = s2_prod_c_r + PROD_W'(1 << 14);
  assign rnd_s     = s2_prod_s_r + PROD_W'(1 << 14);
  assign mag_out_c = rnd_c[15 +: SAMPLE_W];
  assign mag_out_s = rnd_s[15 +: SAMPLE_W];

  assign out_push          = s2_v_r;
  assign out_data.last     = s2_last_r;
  assign out_data.i_sample = s2_neg_c_r ? (~mag_out_c + 1'b1) : mag_out_c;
  assign out_data.q_sample = s2_neg_s_r ? (~mag_out_s + 1'b1) : mag_out_s;

endmodule

// ===== sv/linear_chirp_generator.sv =====
// Linear FM chirp generator top level: config registers, job queue, sample engine.
// A render transfer reaches its first sample through the job queue, the engine's job load and
// issue, the ROM and product registers and the output queue. Throughput: one sample per cycle
// within a request while the output queue has room; the engine loads each request's job first.
// A restart transfer yields no samples.
// Reset (rst_n low, synchronous): queues empty, progress cleared, registers to defaults.
module linear_chirp_generator import lcg_pkg::*; #(
  parameter int unsigned MAX_BURST  = MAX_BURST_DEF,
  parameter int unsigned TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [6:0] count, [7] zero
  input  logic                  in_tuser,   // [0] cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [15:0] i_sample, [31:16] q_sample
  output logic                  out_tlast
);

  logic [PHASE_W-1:0] start_step_r;
  logic [PHASE_W-1:0] sweep_step_r;
  logic [AMP_W-1:0]   amplitude_r;
  logic [TOTAL_W-1:0] chirp_len_r;

  logic                    job_push;
  job_t                    job_in;
  job_t                    job_out;
  logic                    job_pop;
  logic                    job_full;
  logic                    job_empty;
  logic [JOB_DEPTH_LOG2:0] job_count;

  logic                    out_push;
  out_item_t               out_in;
  out_item_t               out_head;
  logic                    out_full;
  logic                    out_empty;
  logic [OUT_DEPTH_LOG2:0] out_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_step_r <= '0;
      sweep_step_r <= '0;
      amplitude_r  <= AMP_RESET;
      chirp_len_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_START_STEP: start_step_r <= cfg_wdata[PHASE_W-1:0];
        REG_SWEEP_STEP: sweep_step_r <= cfg_wdata[PHASE_W-1:0];
        REG_AMPLITUDE:  amplitude_r  <= cfg_wdata[AMP_W-1:0];
        REG_CHIRP_LEN:  chirp_len_r  <= cfg_wdata[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  lcg_front #(
    .MAX_BURST(MAX_BURST)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tuser),
    .in_count (in_tdata[COUNT_W-1:0]),
    .chirp_len(chirp_len_r),
    .job_full (job_full),
    .job_push (job_push),
    .job_data (job_in)
  );

  lcg_fifo #(
    .WIDTH     ($bits(job_t)),
    .DEPTH_LOG2(JOB_DEPTH_LOG2)
  ) u_job_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_data(job_in),
    .pop      (job_pop),
    .pop_data (job_out),
    .full     (job_full),
    .empty    (job_empty),
    .count    (job_count)
  );

  lcg_back #(
    .TABLE_BITS(TABLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_data  (job_out),
    .job_pop   (job_pop),
    .start_step(start_step_r),
    .sweep_step(sweep_step_r),
    .amplitude (amplitude_r),
    .out_count (out_count),
    .out_push  (out_push),
    .out_data  (out_in)
  );

  lcg_fifo #(
    .WIDTH     ($bits(out_item_t)),
    .DEPTH_LOG2(OUT_DEPTH_LOG2)
  ) u_out_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (out_push),
    .push_data(out_in),
    .pop      (out_tvalid && out_tready),
    .pop_data (out_head),
    .full     (out_full),
    .empty    (out_empty),
    .count    (out_count)
  );

  assign out_tvalid = !out_empty;
  assign out_tdata  = {out_head.q_sample, out_head.i_sample};
  assign out_tlast  = out_head.last;

  assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (job_in.n != '0) && (job_in.n <= COUNT_W'(MAX_BURST)))
    else $error("queued job has an empty or oversized burst");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == CMD_RESTART)) |-> !job_push)
    else $error("restart transfer queued a render job");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full)
    else $error("sample written into a full output queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    (job_count != '0) |-> !job_empty)
    else $error("job queue count and empty flag disagree");

endmodule
